// ===== rtl/session_table_lru_expiry_macros.svh =====
// assertion macros for the session table
`ifndef SESSION_TABLE_LRU_EXPIRY_MACROS_SVH
`define SESSION_TABLE_LRU_EXPIRY_MACROS_SVH

// same-cycle implication, checked out of reset
`define STLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define STLE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/stle_pkg.sv =====
// types and constants shared by the session table modules
`timescale 1ns / 1ps

package stle_pkg;

    localparam int NUM_SLOTS_DEF  = 64;
    localparam int TOKEN_BITS_DEF = 64;

    localparam int OPCODE_W = 2;
    localparam int TOKEN_W  = 64;
    localparam int USER_W   = 64;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int USED_W   = 7;

    // input tdata: opcode, token, user_id, now, zero pad
    localparam int IN_OP_LSB    = 0;
    localparam int IN_TOKEN_LSB = IN_OP_LSB + OPCODE_W;
    localparam int IN_USER_LSB  = IN_TOKEN_LSB + TOKEN_W;
    localparam int IN_NOW_LSB   = IN_USER_LSB + USER_W;
    localparam int IN_BITS      = IN_NOW_LSB + TIME_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output tdata: status, slot, found_user, created_time, slots_used
    localparam int OUT_TDATA_W = STATUS_W + SLOT_W + USER_W + TIME_W + USED_W;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(86400);

    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE   = 2'd0,
        OP_VALIDATE = 2'd1,
        OP_DESTROY  = 2'd2
    } t_opcode;

    localparam logic [STATUS_W-1:0] ST_CREATED_FREE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED_EVICT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_VALID         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DESTROYED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DESTROY_MISS  = 3'd6;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ACT
    } t_state;

    typedef struct packed {
        logic clr_run;
        logic scan_start;
        logic scan_run;
        logic act_go;
    } t_stle_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
    } t_stle_sts;

endpackage

// ===== rtl/stle_ctrl.sv =====
// control state machine: clearing pass, scan sequencing, result register handshake
`timescale 1ns / 1ps

module stle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  stle_pkg::t_stle_sts i_sts,
    output stle_pkg::t_stle_cmd o_cmd
);
    import stle_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   act_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_ACT;
            end
            S_ACT: begin
                if (act_go) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // the act step waits while the result register still holds an untaken result
    always_comb begin
        act_go           = (r_state == S_ACT) && (!r_out_valid || i_m_tready);
        o_s_tready       = (r_state == S_IDLE);
        o_cmd.clr_run    = (r_state == S_CLEAR);
        o_cmd.scan_start = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.scan_run   = (r_state == S_SCAN);
        o_cmd.act_go     = act_go;
        n_out_valid      = act_go || (r_out_valid && !i_m_tready);
        o_m_tvalid       = r_out_valid;
    end

endmodule

// ===== rtl/stle_dp.sv =====
// slot memory, scan trackers, operation logic and result register
`timescale 1ns / 1ps

module stle_dp #(
    parameter int NUM_SLOTS  = stle_pkg::NUM_SLOTS_DEF,
    parameter int TOKEN_BITS = stle_pkg::TOKEN_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stle_pkg::t_stle_cmd                 i_cmd,
    output stle_pkg::t_stle_sts                 o_sts,
    input  logic                                i_cfg_wr_en,
    input  logic [stle_pkg::TIME_W-1:0]         i_cfg_wr_data,
    input  logic [stle_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic [stle_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import stle_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int W_TOK_LSB  = 1;
    localparam int W_USER_LSB = W_TOK_LSB + TOKEN_BITS;
    localparam int W_CRT_LSB  = W_USER_LSB + USER_W;
    localparam int W_LAST_LSB = W_CRT_LSB + TIME_W;
    localparam int MW         = W_LAST_LSB + TIME_W;
    localparam logic [CW-1:0] END_CNT = CW'(NUM_SLOTS);

    // slot memory: valid, token, user, created, last active
    logic [MW-1:0] mem [NUM_SLOTS];

    logic [TIME_W-1:0]     r_timeout;
    logic [OPCODE_W-1:0]   r_op;
    logic [TOKEN_BITS-1:0] r_tok;
    logic signed [USER_W-1:0] r_user;
    logic [TIME_W-1:0]     r_now;

    logic [CW-1:0]   r_cnt;
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    logic [MW-1:0]   r_rd_data;

    logic            r_have_free;
    logic [IW-1:0]   r_free_idx;
    logic            r_have_best;
    logic [IW-1:0]   r_oldest_idx;
    logic [TIME_W-1:0] r_best_time;
    logic            r_have_match;
    logic [IW-1:0]   r_match_idx;
    logic signed [USER_W-1:0] r_match_user;
    logic [TIME_W-1:0] r_match_created;

    logic [CW-1:0]   r_hw;
    logic [CW-1:0]   n_hw;

    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic signed [USER_W-1:0] r_res_user;
    logic [TIME_W-1:0]   r_res_created;
    logic [USED_W-1:0]   r_res_used;

    logic                cnt_live;
    logic                rd_en;
    logic                rd_valid;
    logic [TOKEN_BITS-1:0] rd_tok;
    logic signed [USER_W-1:0] rd_user;
    logic [TIME_W-1:0]   rd_created;
    logic [TIME_W-1:0]   rd_last;

    logic                act_we;
    logic [IW-1:0]       act_idx;
    logic [MW-1:0]       act_word;
    logic [STATUS_W-1:0] act_status;
    logic [IW-1:0]       act_slot;
    logic signed [USER_W-1:0] act_user;
    logic [TIME_W-1:0]   act_created;
    logic [TIME_W-1:0]   age;
    logic                expired;
    logic [IW-1:0]       pick;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [MW-1:0]       mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_op   <= i_s_tdata[IN_OP_LSB +: OPCODE_W];
            r_tok  <= i_s_tdata[IN_TOKEN_LSB +: TOKEN_BITS];
            r_user <= i_s_tdata[IN_USER_LSB +: USER_W];
            r_now  <= i_s_tdata[IN_NOW_LSB +: TIME_W];
        end
    end

    assign cnt_live = (r_cnt != END_CNT);
    assign rd_en    = i_cmd.scan_run && cnt_live;

    // address counter, shared by the clearing pass and the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if ((i_cmd.clr_run || i_cmd.scan_run) && cnt_live) r_cnt <= r_cnt + 1'b1;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_cnt[IW-1:0]];
            r_rd_idx  <= r_cnt[IW-1:0];
        end
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    assign rd_valid   = r_rd_data[0];
    assign rd_tok     = r_rd_data[W_TOK_LSB +: TOKEN_BITS];
    assign rd_user    = r_rd_data[W_USER_LSB +: USER_W];
    assign rd_created = r_rd_data[W_CRT_LSB +: TIME_W];
    assign rd_last    = r_rd_data[W_LAST_LSB +: TIME_W];

    // first free slot, least recently active valid slot, first token match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_start) begin
            r_have_free  <= 1'b0;
            r_have_best  <= 1'b0;
            r_have_match <= 1'b0;
        end else if (r_rd_vld) begin
            if (!rd_valid && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_rd_idx;
            end
            if (rd_valid && (!r_have_best || (rd_last < r_best_time))) begin
                r_have_best  <= 1'b1;
                r_best_time  <= rd_last;
                r_oldest_idx <= r_rd_idx;
            end
            if (rd_valid && (rd_tok == r_tok) && !r_have_match) begin
                r_have_match    <= 1'b1;
                r_match_idx     <= r_rd_idx;
                r_match_user    <= rd_user;
                r_match_created <= rd_created;
            end
        end
    end

    assign o_sts.scan_done = !cnt_live && !r_rd_vld;
    assign o_sts.clr_done  = !cnt_live;

    assign pick    = r_have_free ? r_free_idx : r_oldest_idx;
    assign age     = r_now - r_match_created;
    assign expired = (age > r_timeout);

    always_comb begin
        act_we      = 1'b0;
        act_idx     = r_match_idx;
        act_word    = '0;
        act_status  = ST_NOT_FOUND;
        act_slot    = '0;
        act_user    = '0;
        act_created = '0;
        n_hw        = r_hw;
        case (t_opcode'(r_op))
            OP_CREATE: begin
                act_we      = 1'b1;
                act_idx     = pick;
                act_word    = {r_now, r_now, r_user, r_tok, 1'b1};
                act_status  = r_have_free ? ST_CREATED_FREE : ST_CREATED_EVICT;
                act_slot    = pick;
                act_user    = r_user;
                act_created = r_now;
                if (CW'(pick) >= r_hw) n_hw = CW'(CW'(pick) + 1'b1);
            end
            OP_VALIDATE: begin
                if (r_have_match) begin
                    act_we   = 1'b1;
                    act_slot = r_match_idx;
                    if (expired) begin
                        act_status = ST_EXPIRED;
                    end else begin
                        // refresh last activity, keep the rest of the slot
                        act_word    = {r_now, r_match_created, r_match_user, r_tok, 1'b1};
                        act_status  = ST_VALID;
                        act_user    = r_match_user;
                        act_created = r_match_created;
                    end
                end
            end
            OP_DESTROY: begin
                if (r_have_match) begin
                    act_we     = 1'b1;
                    act_status = ST_DESTROYED;
                    act_slot   = r_match_idx;
                end else begin
                    act_status = ST_DESTROY_MISS;
                end
            end
            default: begin
                act_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.clr_run) begin
            mem_we    = cnt_live;
            mem_waddr = r_cnt[IW-1:0];
            mem_wdata = '0;
        end else begin
            mem_we    = i_cmd.act_go && act_we;
            mem_waddr = act_idx;
            mem_wdata = act_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= '0;
        end else if (i_cmd.act_go) begin
            r_hw <= n_hw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_go) begin
            r_res_status  <= act_status;
            r_res_slot    <= SLOT_W'(act_slot);
            r_res_user    <= act_user;
            r_res_created <= act_created;
            r_res_used    <= USED_W'(n_hw);
        end
    end

    assign o_m_tdata = {r_res_used, r_res_created, r_res_user, r_res_slot, r_res_status};

endmodule

// ===== rtl/session_table_lru_expiry.sv =====
// Session table with least-recently-active eviction and timeout on validate.
// Input stream (s side): one transfer per operation - create, validate or
// destroy - carrying the token, the user id and the current time.
// Output stream (m side): one transfer per operation with status, slot,
// user, creation time and the high-water slot count.
// Config: session timeout in seconds, written with i_cfg_wr_en while idle.
// Each operation reads every slot of the slot memory, one entry per cycle
// through its single read port, then updates at most one slot, and handles
// one operation at a time. The next input is taken as soon as the result
// is loaded into the output register, even if the receiver has not taken
// it yet.
// If the receiver stalls, a finished operation waits before its slot update
// until the output register is free; no result is dropped.
// After reset the slot memory is cleared one entry per cycle; no input is
// taken until that clearing pass is done; the timeout resets to 86400.
`timescale 1ns / 1ps
`include "session_table_lru_expiry_macros.svh"

module session_table_lru_expiry #(
    parameter int NUM_SLOTS  = stle_pkg::NUM_SLOTS_DEF,
    parameter int TOKEN_BITS = stle_pkg::TOKEN_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [stle_pkg::TIME_W-1:0]      i_cfg_wr_data,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // opcode, token, user_id, now, zero pad
    input  logic [stle_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status, slot, found_user, created_time, slots_used
    output logic [stle_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import stle_pkg::*;

    localparam bit USED_FITS = (NUM_SLOTS < 128);

    t_stle_cmd cmd;
    t_stle_sts sts;

    stle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stle_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (i_s_tdata),
        .o_m_tdata     (o_m_tdata)
    );

    `STLE_ASSERT_NXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready,
        "input taken during scan")
    `STLE_ASSERT_NXT(a_act_loads_out, cmd.act_go, o_m_tvalid,
        "result lost after slot update")
    `STLE_ASSERT_IMP(a_create_counts,
        USED_FITS && o_m_tvalid && (o_m_tdata[2:0] == ST_CREATED_FREE
            || o_m_tdata[2:0] == ST_CREATED_EVICT),
        o_m_tdata[111:105] != 7'd0, "create left zero slot count")
    `STLE_ASSERT_IMP(a_miss_zero,
        o_m_tvalid && (o_m_tdata[2:0] == ST_NOT_FOUND
            || o_m_tdata[2:0] == ST_DESTROY_MISS),
        o_m_tdata[104:3] == '0, "miss carries slot data")

endmodule

// ===== test/tb_session_table_lru_expiry.sv =====
// testbench for the session table: directed and random streams checked against a shadow table
`timescale 1ns / 1ps

module tb_session_table_lru_expiry;
    import stle_pkg::*;

    localparam int NUM          = NUM_SLOTS_DEF;
    localparam int POOL         = 72;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 222;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // result field offsets in o_m_tdata
    localparam int OUT_ST_LSB   = 0;
    localparam int OUT_SLOT_LSB = OUT_ST_LSB + STATUS_W;
    localparam int OUT_USER_LSB = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_TIME_LSB = OUT_USER_LSB + USER_W;
    localparam int OUT_USED_LSB = OUT_TIME_LSB + TIME_W;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [TOKEN_W-1:0]  token;
        logic [USER_W-1:0]   user;
        logic [TIME_W-1:0]   now;
    } session_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [USER_W-1:0]   user;
        logic [TIME_W-1:0]   created;
        logic [USED_W-1:0]   used;
    } session_resp_t;

    class session_scoreboard;
        bit                 slot_live [NUM];
        logic [TOKEN_W-1:0] slot_tok  [NUM];
        logic [USER_W-1:0]  slot_usr  [NUM];
        logic [TIME_W-1:0]  slot_born [NUM];
        logic [TIME_W-1:0]  slot_seen [NUM];
        int                 high_water;
        logic [TIME_W-1:0]  timeout = TIMEOUT_RST;
        session_resp_t      expected_q[$];
        int                 errors;

        function void set_timeout(logic [TIME_W-1:0] v);
            timeout = v;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function int find_token(logic [TOKEN_W-1:0] tok);
            for (int i = 0; i < NUM; i++) begin
                if (slot_live[i] && slot_tok[i] == tok)
                    return i;
            end
            return NUM;
        endfunction

        function void clear_slot(int i);
            slot_live[i] = 1'b0;
            slot_tok[i]  = '0;
            slot_usr[i]  = '0;
            slot_born[i] = '0;
            slot_seen[i] = '0;
        endfunction

        function void note_request(session_req_t rq);
            session_resp_t    r;
            int               pick;
            int               oldest;
            logic [TIME_W-1:0] best;
            r = '0;
            r.status = ST_NOT_FOUND;
            pick = NUM;
            oldest = 0;
            best = '0;
            case (rq.op)
                OP_CREATE: begin
                    for (int i = 0; i < NUM; i++) begin
                        if (!slot_live[i]) begin
                            pick = i;
                            break;
                        end
                        if (i == 0 || slot_seen[i] < best) begin
                            best = slot_seen[i];
                            oldest = i;
                        end
                    end
                    if (pick < NUM) begin
                        r.status = ST_CREATED_FREE;
                    end else begin
                        pick = oldest;
                        r.status = ST_CREATED_EVICT;
                    end
                    slot_live[pick] = 1'b1;
                    slot_tok[pick]  = rq.token;
                    slot_usr[pick]  = rq.user;
                    slot_born[pick] = rq.now;
                    slot_seen[pick] = rq.now;
                    if (pick >= high_water)
                        high_water = pick + 1;
                    r.slot = pick[SLOT_W-1:0];
                    r.user = rq.user;
                    r.created = rq.now;
                end
                OP_VALIDATE: begin
                    pick = find_token(rq.token);
                    if (pick < NUM) begin
                        r.slot = pick[SLOT_W-1:0];
                        // age wraps modulo 2^32
                        if (TIME_W'(rq.now - slot_born[pick]) > timeout) begin
                            clear_slot(pick);
                            r.status = ST_EXPIRED;
                        end else begin
                            slot_seen[pick] = rq.now;
                            r.status = ST_VALID;
                            r.user = slot_usr[pick];
                            r.created = slot_born[pick];
                        end
                    end
                end
                OP_DESTROY: begin
                    pick = find_token(rq.token);
                    if (pick < NUM) begin
                        clear_slot(pick);
                        r.status = ST_DESTROYED;
                        r.slot = pick[SLOT_W-1:0];
                    end else begin
                        r.status = ST_DESTROY_MISS;
                    end
                end
                default: begin
                end
            endcase
            r.used = high_water[USED_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
            end
        endfunction

        function void check_response(logic [OUT_TDATA_W-1:0] d);
            session_resp_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, d);
                return;
            end
            e = expected_q.pop_front();
            field_check("status", 64'(e.status), 64'(d[OUT_ST_LSB +: STATUS_W]));
            field_check("slot", 64'(e.slot), 64'(d[OUT_SLOT_LSB +: SLOT_W]));
            field_check("found_user", e.user, d[OUT_USER_LSB +: USER_W]);
            field_check("created_time", 64'(e.created), 64'(d[OUT_TIME_LSB +: TIME_W]));
            field_check("slots_used", 64'(e.used), 64'(d[OUT_USED_LSB +: USED_W]));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [TIME_W-1:0]      i_cfg_wr_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    session_scoreboard sb;
    logic [TOKEN_W-1:0] token_pool [POOL];
    logic [TIME_W-1:0]  sim_now;
    bit                 tx_idle = 1'b1;
    bit                 rx_idle = 1'b1;
    int                 hold_reqs = 0;
    int                 idle_cycles = 0;

    session_table_lru_expiry u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic session_req_t mk_req(logic [OPCODE_W-1:0] op, logic [TOKEN_W-1:0] tok,
                                            logic [USER_W-1:0] usr, logic [TIME_W-1:0] now);
        session_req_t rq;
        rq.op = op;
        rq.token = tok;
        rq.user = usr;
        rq.now = now;
        return rq;
    endfunction

    function automatic session_req_t random_req();
        session_req_t rq;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            rq.op = OP_CREATE;
        else if (r < 75)
            rq.op = OP_VALIDATE;
        else if (r < 93)
            rq.op = OP_DESTROY;
        else
            rq.op = OP_UNUSED;
        if ($urandom_range(0, 9) == 0)
            rq.token = {$urandom, $urandom};
        else
            rq.token = token_pool[$urandom_range(0, POOL - 1)];
        case ($urandom_range(0, 19))
            0:       rq.user = {1'b1, {(USER_W-1){1'b0}}};
            1:       rq.user = {1'b0, {(USER_W-1){1'b1}}};
            2:       rq.user = '1;
            3:       rq.user = '0;
            default: rq.user = {$urandom, $urandom};
        endcase
        // mostly a steady clock, now and then a jump anywhere (backward too)
        if ($urandom_range(0, 49) == 0)
            sim_now = $urandom;
        else
            sim_now = sim_now + TIME_W'($urandom_range(0, 30));
        rq.now = sim_now;
        return rq;
    endfunction

    task automatic send_req(input session_req_t rq, input bit no_gap);
        int gap;
        gap = (no_gap || !tx_idle) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, rq.now, rq.user, rq.token, rq.op};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        // let the slot update settle before touching the register
        repeat (4) @(negedge i_clk);
    endtask

    // transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_request(mk_req(i_s_tdata[IN_OP_LSB +: OPCODE_W],
                                       i_s_tdata[IN_TOKEN_LSB +: TOKEN_W],
                                       i_s_tdata[IN_USER_LSB +: USER_W],
                                       i_s_tdata[IN_NOW_LSB +: TIME_W]));
            if (o_m_tvalid && i_m_tready)
                sb.check_response(o_m_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver
    initial begin
        int stall;
        int taken;
        int holds_done;
        i_m_tready = 1'b0;
        taken = 0;
        holds_done = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_reqs > holds_done) begin
                stall = HOLD_CYCLES;
                holds_done++;
            end else begin
                stall = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            @(negedge i_clk);
            taken++;
            if (taken % 40 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
        end
    end

    // stimulus
    initial begin
        logic [TIME_W-1:0] phase_timeout [6];
        logic [TOKEN_W-1:0] all_ones;
        int burst;
        all_ones = '1;
        burst = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        sb = new;
        token_pool[0] = '0;
        token_pool[1] = '1;
        token_pool[2] = {1'b1, {(TOKEN_W-1){1'b0}}};
        for (int i = 3; i < POOL; i++)
            token_pool[i] = {$urandom, $urandom};
        phase_timeout[0] = TIMEOUT_RST;
        phase_timeout[1] = '0;
        phase_timeout[2] = '1;
        phase_timeout[3] = TIME_W'(60);
        phase_timeout[4] = TIME_W'($urandom_range(1, 2000));
        phase_timeout[5] = TIMEOUT_RST;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, wrapped age, unused opcode, duplicates
        send_req(mk_req(OP_VALIDATE, '0, '0, '0), 1'b0);
        send_req(mk_req(OP_DESTROY, '0, '0, '0), 1'b0);
        send_req(mk_req(OP_CREATE, '0, {1'b1, {(USER_W-1){1'b0}}}, '0), 1'b0);
        send_req(mk_req(OP_CREATE, all_ones, {1'b0, {(USER_W-1){1'b1}}}, '1), 1'b0);
        send_req(mk_req(OP_VALIDATE, '0, '1, TIMEOUT_RST), 1'b0);
        send_req(mk_req(OP_VALIDATE, '0, '0, TIMEOUT_RST + 1), 1'b0);
        send_req(mk_req(OP_VALIDATE, all_ones, '0, TIMEOUT_RST - 1), 1'b0);
        send_req(mk_req(OP_VALIDATE, all_ones, '0, TIMEOUT_RST), 1'b0);
        send_req(mk_req(OP_UNUSED, all_ones, '1, '1), 1'b0);
        send_req(mk_req(OP_DESTROY, all_ones, '0, '0), 1'b0);
        send_req(mk_req(OP_DESTROY, all_ones, '0, '0), 1'b0);
        send_req(mk_req(OP_CREATE, TOKEN_W'(5), '1, TIME_W'(100)), 1'b0);
        send_req(mk_req(OP_CREATE, TOKEN_W'(5), TOKEN_W'(7), TIME_W'(101)), 1'b0);
        send_req(mk_req(OP_VALIDATE, TOKEN_W'(5), '0, TIME_W'(102)), 1'b0);
        send_req(mk_req(OP_DESTROY, TOKEN_W'(5), '0, TIME_W'(103)), 1'b0);
        send_req(mk_req(OP_VALIDATE, TOKEN_W'(5), '0, TIME_W'(104)), 1'b0);
        send_req(mk_req(OP_CREATE, '0, '0, '1), 1'b0);
        send_req(mk_req(OP_VALIDATE, '0, '0, TIMEOUT_RST - 1), 1'b0);
        sim_now = TIME_W'(200);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                i_cfg_wr_en   <= 1'b1;
                i_cfg_wr_data <= phase_timeout[ph];
                @(negedge i_clk);
                i_cfg_wr_en   <= 1'b0;
                sb.set_timeout(phase_timeout[ph]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((ph == 1 || ph == 4) && n == 40) begin
                    hold_reqs++;
                    burst = 30;
                end
                if (n % 64 == 0)
                    tx_idle = ($urandom_range(0, 2) != 0);
                send_req(random_req(), burst > 0);
                if (burst > 0)
                    burst--;
            end
        end

        drain();
        repeat (70) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/stle_pkg.sv
rtl/stle_ctrl.sv
rtl/stle_dp.sv
rtl/session_table_lru_expiry.sv
test/tb_session_table_lru_expiry.sv
